/* sv/ring_cache_slot_allocator_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the ring cache slot allocator
// Same-cycle and next-cycle implication checks with synchronous reset gating.
// ----------------------------------------------------------------------------
`ifndef RING_CACHE_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define RING_CACHE_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define RCSA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcsa check failed: same-cycle rule");

// Check that the consequent holds in the cycle after the antecedent.
`define RCSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcsa check failed: next-cycle rule");

`endif

/* sv/rcsa_pkg.sv */
// ----------------------------------------------------------------------------
// rcsa_pkg
// Shared widths, codes and types of the ring cache slot allocator.
// ----------------------------------------------------------------------------
package rcsa_pkg;

    localparam int SLOTS      = 24;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int ID_W       = 12;
    localparam int BYTE_W     = 20;
    localparam int AGE_W      = 32;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 5;

    localparam logic [BYTE_W-1:0] CAP_RESET  = BYTE_W'(163840);
    localparam logic [BYTE_W:0]   GRAIN_MASK = (BYTE_W + 1)'(31);

    // Transaction modes
    localparam logic [MODE_W-1:0] MODE_REQ   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_HIT    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALLOC  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd3;

    // One slot table entry as stored in the slot memory
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [BYTE_W-1:0] start;
        logic [BYTE_W-1:0] length;
        logic [AGE_W-1:0]  last_use;
    } t_slot_entry;

    localparam int ENTRY_W = $bits(t_slot_entry);

    // Per-entry findings of the table walk
    typedef struct packed {
        logic hit;
        logic overlap;
        logic older;
    } t_slot_eval;

endpackage

/* sv/rcsa_slot_ram.sv */
// ----------------------------------------------------------------------------
// rcsa_slot_ram
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rcsa_slot_ram #(
    parameter int DEPTH = 24,
    parameter int WIDTH = 84
) (
    input  logic                             i_clk,
    input  logic                             i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]         i_rd_addr,
    output logic [WIDTH-1:0]                 o_rd_data,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]         i_wr_addr,
    input  logic [WIDTH-1:0]                 i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/rcsa_slot_eval.sv */
// ----------------------------------------------------------------------------
// rcsa_slot_eval
// Evaluates one slot entry during the table walk: id match, overlap with
// the new region, and age order against the oldest entry seen so far.
// ----------------------------------------------------------------------------
module rcsa_slot_eval (
    input  rcsa_pkg::t_slot_entry              i_entry,
    input  logic                               i_valid,
    input  logic                               i_first,
    input  logic [rcsa_pkg::ID_W-1:0]          i_id,
    input  logic [rcsa_pkg::BYTE_W-1:0]        i_lo,
    input  logic [rcsa_pkg::BYTE_W:0]          i_hi,
    input  logic [rcsa_pkg::AGE_W-1:0]         i_min_age,
    output rcsa_pkg::t_slot_eval               o_eval
);

    import rcsa_pkg::*;

    logic [BYTE_W:0] w_end;

    // End of the stored region, one bit wider to keep the carry
    assign w_end = {1'b0, i_entry.start} + {1'b0, i_entry.length};

    assign o_eval.hit     = i_valid && (i_entry.id == i_id);
    assign o_eval.overlap = i_valid && ({1'b0, i_entry.start} < i_hi) &&
                            ({1'b0, i_lo} < w_end);
    assign o_eval.older   = i_first || (i_entry.last_use < i_min_age);

endmodule

/* sv/ring_cache_slot_allocator_unit.sv */
// ----------------------------------------------------------------------------
// ring_cache_slot_allocator_unit
// Slot allocator for a linear cache region, slot table held in one RAM.
// Tick, flush and unused modes: result registered in the cycle after acceptance.
// Request: the walk reads the slot RAM, one read a cycle, then the result is
//   loaded once the output register is free; no new request is taken until then.
// Reset clears valid bits, cursor and age counter and sets capacity (163840)
//   at once; slot RAM contents stay undefined, no clearing pass.
// ----------------------------------------------------------------------------
module ring_cache_slot_allocator_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [rcsa_pkg::MODE_W-1:0]           i_mode,
    input  logic [rcsa_pkg::ID_W-1:0]             i_item_id,
    input  logic [rcsa_pkg::BYTE_W-1:0]           i_item_size,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [rcsa_pkg::STATUS_W-1:0]         o_status,
    output logic [rcsa_pkg::SLOT_OUT_W-1:0]       o_slot,
    output logic [rcsa_pkg::BYTE_W-1:0]           o_region_start,
    output logic [rcsa_pkg::BYTE_W-1:0]           o_region_size,
    input  logic                                  i_cfg_we,
    input  logic [rcsa_pkg::BYTE_W-1:0]           i_cfg_wdata
);

    import rcsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [SLOTS-1:0]    r_valid;
    logic [SLOTS-1:0]    r_kill;
    logic [BYTE_W-1:0]   r_cursor;
    logic [AGE_W-1:0]    r_age;
    logic [BYTE_W-1:0]   r_cap;

    // Request context
    logic [ID_W-1:0]     r_id;
    logic [BYTE_W-1:0]   r_rounded;
    logic                r_reject;
    logic [BYTE_W-1:0]   r_lo;
    logic [BYTE_W:0]     r_hi;

    // Walk state
    logic [CNT_W-1:0]    r_rd_idx;
    logic                r_cmp_vld;
    logic [SLOT_W-1:0]   r_cmp_idx;
    logic                r_hit;
    logic [SLOT_W-1:0]   r_hit_idx;
    t_slot_entry         r_hit_entry;
    logic [AGE_W-1:0]    r_min_age;
    logic [SLOT_W-1:0]   r_lru_idx;

    // Output register
    logic                r_out_vld;
    logic [STATUS_W-1:0] r_status;
    logic [SLOT_OUT_W-1:0] r_slot;
    logic [BYTE_W-1:0]   r_start;
    logic [BYTE_W-1:0]   r_size;

    logic                w_in_acc;
    logic                w_out_free;
    logic                w_out_load;
    logic [BYTE_W:0]     w_round_sum;
    logic [BYTE_W:0]     w_rounded;
    logic                w_reject;
    logic                w_wrap;
    logic [BYTE_W-1:0]   w_lo;
    logic [BYTE_W:0]     w_hi;
    logic                w_rd_en;
    logic                w_scan_last;
    t_slot_entry         w_rd_entry;
    t_slot_eval          w_eval;
    logic [SLOTS-1:0]    w_live;
    logic                w_free_found;
    logic [SLOT_W-1:0]   w_free_idx;
    logic [SLOT_W-1:0]   w_victim;
    logic                w_wr_en;
    logic [SLOT_W-1:0]   w_wr_addr;
    t_slot_entry         w_wr_entry;
    logic [STATUS_W-1:0] w_res_status;
    logic [SLOT_OUT_W-1:0] w_res_slot;
    logic [BYTE_W-1:0]   w_res_start;
    logic [BYTE_W-1:0]   w_res_size;

    // Handshakes
    assign w_out_free = !r_out_vld || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && (w_out_free || (i_mode == MODE_REQ));
    assign w_in_acc   = i_in_valid && o_in_ready;

    // Round size up to the 32-byte grain and check it against the capacity
    assign w_round_sum = {1'b0, i_item_size} + GRAIN_MASK;
    assign w_rounded   = w_round_sum & ~GRAIN_MASK;
    assign w_reject    = (i_item_size > r_cap) || w_rounded[BYTE_W];

    // Place the region, wrapping to zero when it would pass the capacity
    assign w_wrap = ({1'b0, r_cursor} + {1'b0, r_rounded}) > {1'b0, r_cap};
    assign w_lo   = w_wrap ? '0 : r_cursor;
    assign w_hi   = {1'b0, w_lo} + {1'b0, r_rounded};

    // Walk the slot RAM, one read a cycle
    assign w_rd_en     = (r_state == S_SCAN) && (r_rd_idx < CNT_W'(SLOTS));
    assign w_scan_last = r_cmp_vld && (r_cmp_idx == SLOT_W'(SLOTS - 1));

    rcsa_slot_ram #(
        .DEPTH (SLOTS),
        .WIDTH (ENTRY_W)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_idx[SLOT_W-1:0]),
        .o_rd_data (w_rd_entry),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_entry)
    );

    rcsa_slot_eval u_slot_eval (
        .i_entry   (w_rd_entry),
        .i_valid   (r_valid[r_cmp_idx]),
        .i_first   (r_cmp_idx == '0),
        .i_id      (r_id),
        .i_lo      (r_lo),
        .i_hi      (r_hi),
        .i_min_age (r_min_age),
        .o_eval    (w_eval)
    );

    // Pick the first slot left invalid after the overlap sweep
    always_comb begin
        w_live       = r_valid & ~r_kill;
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!w_live[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = SLOT_W'(i);
            end
        end
    end

    assign w_victim = w_free_found ? w_free_idx : r_lru_idx;

    // Resolve the request: write back the slot and form the result
    always_comb begin
        w_wr_en      = 1'b0;
        w_wr_addr    = r_hit_idx;
        w_wr_entry   = r_hit_entry;
        w_res_status = ST_REJECT;
        w_res_slot   = '0;
        w_res_start  = '0;
        w_res_size   = '0;
        if (r_hit) begin
            w_wr_en             = (r_state == S_DONE) && w_out_free;
            w_wr_entry.last_use = r_age;
            w_res_status        = ST_HIT;
            w_res_slot          = SLOT_OUT_W'(r_hit_idx);
            w_res_start         = r_hit_entry.start;
            w_res_size          = r_hit_entry.length;
        end else if (!r_reject) begin
            w_wr_en             = (r_state == S_DONE) && w_out_free;
            w_wr_addr           = w_victim;
            w_wr_entry.id       = r_id;
            w_wr_entry.start    = r_lo;
            w_wr_entry.length   = r_rounded;
            w_wr_entry.last_use = r_age;
            w_res_status        = ST_ALLOC;
            w_res_slot          = SLOT_OUT_W'(w_victim);
            w_res_start         = r_lo;
            w_res_size          = r_rounded;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_mode == MODE_REQ)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_out_load = ((r_state == S_IDLE) && w_in_acc && (i_mode != MODE_REQ)) ||
                        ((r_state == S_DONE) && w_out_free);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_cursor  <= '0;
            r_age     <= '0;
            r_cap     <= CAP_RESET;
            r_out_vld <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_rd_idx  <= '0;
            r_hit     <= 1'b0;
            r_kill    <= '0;
        end else begin
            r_state <= n_state;

            // Capacity register write
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end

            // Drop the result once taken, load a new one when ready
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            // Tick and flush act at acceptance
            if ((r_state == S_IDLE) && w_in_acc) begin
                if (i_mode == MODE_TICK) begin
                    r_age <= r_age + AGE_W'(1);
                end
                if (i_mode == MODE_FLUSH) begin
                    r_valid  <= '0;
                    r_cursor <= '0;
                end
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
                r_hit     <= 1'b0;
                r_kill    <= '0;
            end

            // Advance the walk
            if (r_state == S_SCAN) begin
                if (w_rd_en) begin
                    r_rd_idx <= r_rd_idx + CNT_W'(1);
                end
                r_cmp_vld <= w_rd_en;
                if (r_cmp_vld) begin
                    if (w_eval.hit && !r_hit) begin
                        r_hit <= 1'b1;
                    end
                    r_kill[r_cmp_idx] <= w_eval.overlap;
                end
            end

            // Commit an allocation
            if ((r_state == S_DONE) && w_out_free && !r_hit && !r_reject) begin
                r_valid  <= w_live | (SLOTS'(1) << w_victim);
                r_cursor <= r_hi[BYTE_W-1:0];
            end
        end
    end

    // Request context and walk payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && w_in_acc) begin
            r_id      <= i_item_id;
            r_rounded <= w_rounded[BYTE_W-1:0];
            r_reject  <= w_reject;
        end
        if ((r_state == S_SCAN) && (r_rd_idx == '0)) begin
            r_lo <= w_lo;
            r_hi <= w_hi;
        end
        if (r_state == S_SCAN) begin
            r_cmp_idx <= r_rd_idx[SLOT_W-1:0];
        end
        if ((r_state == S_SCAN) && r_cmp_vld) begin
            if (w_eval.hit && !r_hit) begin
                r_hit_idx   <= r_cmp_idx;
                r_hit_entry <= w_rd_entry;
            end
            if (w_eval.older) begin
                r_min_age <= w_rd_entry.last_use;
                r_lru_idx <= r_cmp_idx;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (r_state == S_DONE) begin
                r_status <= w_res_status;
                r_slot   <= w_res_slot;
                r_start  <= w_res_start;
                r_size   <= w_res_size;
            end else begin
                r_status <= ST_DONE;
                r_slot   <= '0;
                r_start  <= '0;
                r_size   <= '0;
            end
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_status       = r_status;
    assign o_slot         = r_slot;
    assign o_region_start = r_start;
    assign o_region_size  = r_size;

endmodule

/* sv/rcsa_checker.sv */
// ----------------------------------------------------------------------------
// rcsa_checker
// Port-level checks of the ring cache slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "ring_cache_slot_allocator_unit_assert.svh"

module rcsa_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  o_in_ready,
    input  logic [rcsa_pkg::MODE_W-1:0]           i_mode,
    input  logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    input  logic [rcsa_pkg::STATUS_W-1:0]         o_status,
    input  logic [rcsa_pkg::SLOT_OUT_W-1:0]       o_slot,
    input  logic [rcsa_pkg::BYTE_W-1:0]           o_region_start,
    input  logic [rcsa_pkg::BYTE_W-1:0]           o_region_size
);

    import rcsa_pkg::*;

    // Hold a stalled result
    `RCSA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_slot) && $stable(o_region_start) && $stable(o_region_size))

    // Rejected and housekeeping results carry no region
    `RCSA_ASSERT_SAME(a_empty_fields, i_clk, i_rst_n, o_out_valid && (o_status == ST_REJECT || o_status == ST_DONE), o_slot == '0 && o_region_start == '0 && o_region_size == '0)

    // Hit and allocated region sizes stay on the 32-byte grain
    `RCSA_ASSERT_SAME(a_grain, i_clk, i_rst_n, o_out_valid && (o_status == ST_HIT || o_status == ST_ALLOC), o_region_size[4:0] == 5'd0)

    // A request transaction keeps the block busy for the walk
    `RCSA_ASSERT_NEXT(a_req_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_mode == MODE_REQ, !o_in_ready)

endmodule

bind ring_cache_slot_allocator_unit rcsa_checker u_rcsa_checker (.*);

/* sim/ring_cache_slot_allocator_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_cache_slot_allocator_unit_test
// Self-checking bench for the slot allocator. A directed table covers the
// special cases; random phases under varied capacities follow. Each
// transaction is mirrored in a local slot table, and each result is checked
// field by field against the oldest pending grant.
// ----------------------------------------------------------------------------
module ring_cache_slot_allocator_unit_test;

    import rcsa_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;
    localparam logic [BYTE_W-1:0] BYTE_MAX     = 20'hFFFFF;
    localparam logic [BYTE_W-1:0] ROUND_LIMIT  = 20'd1048544;
    localparam int                DRAIN_GUARD  = 40;
    localparam int                PHASES       = 8;
    localparam int                PHASE_ITEMS  = 150;
    localparam longint            RUN_LIMIT_NS = 64'd4_000_000;

    typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_e;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [BYTE_W-1:0]     start;
        logic [BYTE_W-1:0]     len;
    } grant_t;

    typedef struct packed {
        row_kind_e         kind;
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   id;
        logic [BYTE_W-1:0] size;
        logic              typed;
        grant_t            want;
    } stim_row_t;

    logic                  i_clk       = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic [MODE_W-1:0]     in_mode     = '0;
    logic [ID_W-1:0]       in_id       = '0;
    logic [BYTE_W-1:0]     in_size     = '0;
    logic                  out_ready   = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [BYTE_W-1:0]     cfg_wdata   = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [SLOT_OUT_W-1:0] o_slot;
    logic [BYTE_W-1:0]     o_region_start;
    logic [BYTE_W-1:0]     o_region_size;

    // Mirror of the slot table
    bit   [SLOTS-1:0]      held_valid;
    logic [ID_W-1:0]       held_id    [SLOTS];
    logic [BYTE_W-1:0]     held_base  [SLOTS];
    logic [BYTE_W-1:0]     held_len   [SLOTS];
    logic [AGE_W-1:0]      held_stamp [SLOTS];
    logic [BYTE_W-1:0]     fill_ptr;
    logic [AGE_W-1:0]      frame_count;
    logic [BYTE_W-1:0]     cap_bytes;

    grant_t                pending_grants[$];
    stim_row_t             directed_rows[$];
    int unsigned           mismatch_count = 0;
    bit                    calm = 1'b0;

    ring_cache_slot_allocator_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_mode         (in_mode),
        .i_item_id      (in_id),
        .i_item_size    (in_size),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_region_start (o_region_start),
        .o_region_size  (o_region_size),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop if the block hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic note_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic void clear_table_mirror();
        held_valid  = '0;
        fill_ptr    = '0;
        frame_count = '0;
        cap_bytes   = CAP_RESET;
    endfunction

    // Apply one transaction to the mirror and return the grant it produces
    function automatic grant_t predict_allocation(input logic [MODE_W-1:0] mode,
                                                  input logic [ID_W-1:0] id,
                                                  input logic [BYTE_W-1:0] size);
        grant_t          res;
        logic [BYTE_W:0] rounded;
        logic [BYTE_W:0] lo;
        logic [BYTE_W:0] hi;
        int              victim;
        bit              found;
        res        = '0;
        res.status = ST_DONE;
        found      = 1'b0;
        victim     = 0;
        if (mode == MODE_TICK) begin
            frame_count = frame_count + 1'b1;
        end else if (mode == MODE_FLUSH) begin
            held_valid = '0;
            fill_ptr   = '0;
        end else if (mode == MODE_REQ) begin
            // Lookup: lowest valid slot with a matching id
            for (int i = 0; i < SLOTS; i++) begin
                if (!found && held_valid[i] && held_id[i] == id) begin
                    found         = 1'b1;
                    held_stamp[i] = frame_count;
                    res.status    = ST_HIT;
                    res.slot      = SLOT_OUT_W'(i);
                    res.start     = held_base[i];
                    res.len       = held_len[i];
                end
            end
            if (!found) begin
                rounded = ({1'b0, size} + GRAIN_MASK) & ~GRAIN_MASK;
                if (size > cap_bytes || rounded > {1'b0, BYTE_MAX}) begin
                    res.status = ST_REJECT;
                end else begin
                    // Wrap when the region would pass the capacity
                    if ({1'b0, fill_ptr} + rounded > {1'b0, cap_bytes})
                        fill_ptr = '0;
                    lo = {1'b0, fill_ptr};
                    hi = lo + rounded;
                    // Drop every slot overlapping the new region
                    for (int i = 0; i < SLOTS; i++) begin
                        if (held_valid[i] && {1'b0, held_base[i]} < hi &&
                            lo < {1'b0, held_base[i]} + {1'b0, held_len[i]})
                            held_valid[i] = 1'b0;
                    end
                    // First free slot, else the oldest stamp
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!held_valid[i]) begin
                            victim = i;
                            break;
                        end
                        if (held_stamp[i] < held_stamp[victim])
                            victim = i;
                    end
                    held_valid[victim] = 1'b1;
                    held_id[victim]    = id;
                    held_base[victim]  = fill_ptr;
                    held_len[victim]   = rounded[BYTE_W-1:0];
                    held_stamp[victim] = frame_count;
                    fill_ptr           = hi[BYTE_W-1:0];
                    res.status         = ST_ALLOC;
                    res.slot           = SLOT_OUT_W'(victim);
                    res.start          = held_base[victim];
                    res.len            = held_len[victim];
                end
            end
        end
        return res;
    endfunction

    function automatic int unsigned draw_wait();
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    // Present one transaction and record its grant once accepted
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                             input logic [BYTE_W-1:0] size, input bit typed,
                             input grant_t want);
        int unsigned gap;
        grant_t      pred;
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_id    <= id;
        in_size  <= size;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        pred = predict_allocation(mode, id, size);
        pending_grants.push_back(typed ? want : pred);
    endtask

    // Hold off input until every pending grant has come back
    task automatic settle_block(input int unsigned extra);
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_grants.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [BYTE_W-1:0] value);
        settle_block(DRAIN_GUARD);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        cap_bytes = value;
    endtask

    function automatic stim_row_t make_row(input row_kind_e kind, input logic [MODE_W-1:0] mode,
                                           input logic [ID_W-1:0] id,
                                           input logic [BYTE_W-1:0] size, input bit typed,
                                           input logic [STATUS_W-1:0] st,
                                           input logic [SLOT_OUT_W-1:0] slot,
                                           input logic [BYTE_W-1:0] start,
                                           input logic [BYTE_W-1:0] len);
        stim_row_t r;
        r.kind        = kind;
        r.mode        = mode;
        r.id          = id;
        r.size        = size;
        r.typed       = typed;
        r.want.status = st;
        r.want.slot   = slot;
        r.want.start  = start;
        r.want.len    = len;
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_size();
        int unsigned r;
        int unsigned cap;
        cap = cap_bytes;
        r   = $urandom_range(0, 99);
        if (r < 65)
            return BYTE_W'($urandom_range(0, cap / 20 + 1));
        if (r < 75)
            return BYTE_W'($urandom_range(0, cap / 640) * 32);
        if (r < 85)
            return BYTE_W'($urandom_range(cap - cap / 8, cap));
        if (r < 95)
            return BYTE_W'($urandom_range(0, BYTE_MAX));
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return ROUND_LIMIT;
            2:       return ROUND_LIMIT + 1'b1;
            3:       return BYTE_MAX;
            4:       return cap_bytes;
            default: return cap_bytes + 1'b1;
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return ID_W'($urandom_range(0, 31));
        if (r < 85)
            return ID_W'($urandom_range(0, 7));
        return ID_W'($urandom_range(0, 4095));
    endfunction

    function automatic logic [BYTE_W-1:0] phase_capacity(input int p);
        case (p)
            1:       return BYTE_MAX;
            2:       return 20'd32;
            4:       return 20'd4100;
            5:       return BYTE_W'($urandom_range(2, 40) * 32);
            3, 6:    return BYTE_W'($urandom_range(32, BYTE_MAX));
            default: return CAP_RESET;
        endcase
    endfunction

    // Result side: random stalls, compare against the oldest grant
    initial begin
        int unsigned stall;
        grant_t      want;
        wait (rst_n == 1'b1);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            if (pending_grants.size() == 0) begin
                note_mismatch($sformatf("result with nothing pending: status %0d slot %0d",
                                        o_status, o_slot));
            end else begin
                want = pending_grants.pop_front();
                if (o_status !== want.status)
                    note_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_slot !== want.slot)
                    note_mismatch($sformatf("slot %0d, want %0d", o_slot, want.slot));
                if (o_region_start !== want.start)
                    note_mismatch($sformatf("region_start 0x%05h, want 0x%05h",
                                            o_region_start, want.start));
                if (o_region_size !== want.len)
                    note_mismatch($sformatf("region_size 0x%05h, want 0x%05h",
                                            o_region_size, want.len));
            end
        end
    end

    // Stimulus: directed table, then random phases
    initial begin
        stim_row_t         row;
        logic [MODE_W-1:0] mode;
        int unsigned       r;
        clear_table_mirror();

        directed_rows.push_back(make_row(ROW_ITEM, MODE_TICK, 0, 0, 1, ST_DONE, 0, 0, 0));
        directed_rows.push_back(make_row(ROW_ITEM, MODE_SPARE, 12'hFFF, BYTE_MAX, 1,
                                         ST_DONE, 0, 0, 0));
        directed_rows.push_back(make_row(ROW_ITEM, MODE_REQ, 0, 0, 1, ST_ALLOC, 0, 0, 0));
        directed_rows.push_back(make_row(ROW_ITEM, MODE_REQ, 12'hFFF, BYTE_MAX, 1,
                                         ST_REJECT, 0, 0, 0));
        directed_rows.push_back(make_row(ROW_ITEM, MODE_REQ, 1, 1, 0, ST_DONE, 0, 0, 0));
        directed_rows.push_back(make_row(ROW_ITEM, MODE_REQ, 0, 7, 1, ST_HIT, 0, 0, 0));
        directed_rows.push_back(make_row(ROW_ITEM, MODE_REQ, 2, CAP_RESET, 0, ST_DONE, 0, 0, 0));
        directed_rows.push_back(make_row(ROW_ITEM, MODE_REQ, 0, 0, 0, ST_DONE, 0, 0, 0));
        directed_rows.push_back(make_row(ROW_ITEM, MODE_FLUSH, 0, 0, 1, ST_DONE, 0, 0, 0));
        directed_rows.push_back(make_row(ROW_ITEM, MODE_REQ, 3, CAP_RESET + 1'b1, 1,
                                         ST_REJECT, 0, 0, 0));
        // Largest capacity: oversize rounding and wrap at the top
        directed_rows.push_back(make_row(ROW_CAP, MODE_REQ, 0, BYTE_MAX, 0, ST_DONE, 0, 0, 0));
        directed_rows.push_back(make_row(ROW_ITEM, MODE_REQ, 4, ROUND_LIMIT + 1'b1, 1,
                                         ST_REJECT, 0, 0, 0));
        directed_rows.push_back(make_row(ROW_ITEM, MODE_REQ, 5, ROUND_LIMIT, 0, ST_DONE, 0, 0, 0));
        directed_rows.push_back(make_row(ROW_ITEM, MODE_REQ, 6, 64, 0, ST_DONE, 0, 0, 0));
        directed_rows.push_back(make_row(ROW_ITEM, MODE_REQ, 12'hABC, 20'h5A5A5, 0,
                                         ST_DONE, 0, 0, 0));
        // Capacity off the grain: rounded region reaches past it
        directed_rows.push_back(make_row(ROW_CAP, MODE_REQ, 0, 20'd100, 0, ST_DONE, 0, 0, 0));
        directed_rows.push_back(make_row(ROW_ITEM, MODE_REQ, 7, 20'd100, 0, ST_DONE, 0, 0, 0));
        // Smallest capacity, now below the cursor
        directed_rows.push_back(make_row(ROW_CAP, MODE_REQ, 0, 20'd32, 0, ST_DONE, 0, 0, 0));
        directed_rows.push_back(make_row(ROW_ITEM, MODE_REQ, 8, 20'd32, 0, ST_DONE, 0, 0, 0));
        directed_rows.push_back(make_row(ROW_ITEM, MODE_REQ, 9, 20'd33, 1, ST_REJECT, 0, 0, 0));
        directed_rows.push_back(make_row(ROW_ITEM, MODE_REQ, 8, 0, 0, ST_DONE, 0, 0, 0));
        directed_rows.push_back(make_row(ROW_ITEM, MODE_TICK, 0, 0, 1, ST_DONE, 0, 0, 0));
        directed_rows.push_back(make_row(ROW_ITEM, MODE_TICK, 12'h555, 20'hAAAAA, 1,
                                         ST_DONE, 0, 0, 0));

        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_CAP)
                write_capacity(row.size);
            else
                send_item(row.mode, row.id, row.size, row.typed, row.want);
        end

        // Random phases, one capacity each
        for (int p = 0; p < PHASES; p++) begin
            write_capacity(phase_capacity(p));
            calm = (p == 2 || p == 5);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 82)
                    mode = MODE_REQ;
                else if (r < 96)
                    mode = MODE_TICK;
                else if (r < 98)
                    mode = MODE_FLUSH;
                else
                    mode = MODE_SPARE;
                send_item(mode, pick_id(), pick_size(), 1'b0, '0);
                // Let the block run dry now and then
                if ((p == 3 && n == PHASE_ITEMS / 2) || $urandom_range(0, 199) == 0)
                    settle_block(0);
            end
        end

        // Drain and close out
        calm = 1'b0;
        settle_block(DRAIN_GUARD);
        if (pending_grants.size() != 0)
            note_mismatch($sformatf("%0d grants never returned", pending_grants.size()));
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
